// ===== hdl/rti_pkg.sv =====
// Shared codes and constants for the ray/triangle intersection pipeline.
package rti_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DET_MIN  = 3'd6;

  localparam logic [1:0] OUTCOME_HIT    = 2'd0;
  localparam logic [1:0] OUTCOME_MISS   = 2'd1;
  localparam logic [1:0] OUTCOME_REJECT = 2'd2;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // Dot products formed in the multiply stages.
  localparam int DOT_DET = 0;
  localparam int DOT_U   = 1;
  localparam int DOT_V   = 2;
  localparam int DOT_T   = 3;

  // Stages ahead of the divider, divider steps, and the result register.
  localparam int FRONT_STAGES = 9;
  localparam int QUOT_BITS    = 32;
  localparam int LATENCY      = FRONT_STAGES + QUOT_BITS + 1;

endpackage

// ===== hdl/ray_triangle_intersect.sv =====
// Pipelined ray/triangle intersection test in signed Q16.16 fixed point.
// The result of each accepted triangle passes every stage below into the result register;
// done is high for one cycle when that result is taken.
// Throughput: one triangle per cycle; busy stays low, and the 42-stage pipeline
// (nine arithmetic stages, 32 restoring-division steps, one result register) never stalls.
// Reset clears the ray registers, det_min and all valid bits.
module ray_triangle_intersect
  import rti_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   vert0_x,
  input  logic signed [31:0]   vert0_y,
  input  logic signed [31:0]   vert0_z,
  input  logic signed [31:0]   vert1_x,
  input  logic signed [31:0]   vert1_y,
  input  logic signed [31:0]   vert1_z,
  input  logic signed [31:0]   vert2_x,
  input  logic signed [31:0]   vert2_y,
  input  logic signed [31:0]   vert2_z,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 done,
  output logic [1:0]           outcome,
  output logic signed [31:0]   hit_distance,
  output logic signed [31:0]   bary_u,
  output logic signed [31:0]   bary_v
);

  // Configuration registers.
  logic signed [31:0] origin [3];
  logic signed [31:0] dir [3];
  logic [30:0]        det_min;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin  <= '{default: '0};
      dir     <= '{default: '0};
      det_min <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin[0] <= cfg_data;
        REG_ORIGIN_Y: origin[1] <= cfg_data;
        REG_ORIGIN_Z: origin[2] <= cfg_data;
        REG_DIR_X:    dir[0]    <= cfg_data;
        REG_DIR_Y:    dir[1]    <= cfg_data;
        REG_DIR_Z:    dir[2]    <= cfg_data;
        REG_DET_MIN:  det_min   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // Stage 1: edges and origin offset.
  logic signed [31:0] v0 [3];
  logic signed [31:0] v1 [3];
  logic signed [31:0] v2 [3];
  logic signed [32:0] s1_e1 [3];
  logic signed [32:0] s1_e2 [3];
  logic signed [32:0] s1_ao [3];
  logic               s1_valid;

  always_comb begin
    v0[0] = vert0_x; v0[1] = vert0_y; v0[2] = vert0_z;
    v1[0] = vert1_x; v1[1] = vert1_y; v1[2] = vert1_z;
    v2[0] = vert2_x; v2[1] = vert2_y; v2[2] = vert2_z;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_e1[i] <= 33'(v1[i]) - 33'(v0[i]);
      s1_e2[i] <= 33'(v2[i]) - 33'(v0[i]);
      s1_ao[i] <= 33'(origin[i]) - 33'(v0[i]);
    end
  end

  // Stage 2: cross-product terms. Stage 3: cross products.
  logic signed [65:0] s2_na [3];
  logic signed [65:0] s2_nb [3];
  logic signed [64:0] s2_pa [3];
  logic signed [64:0] s2_pb [3];
  logic signed [32:0] s2_e1 [3];
  logic signed [32:0] s2_e2 [3];
  logic signed [32:0] s2_ao [3];
  logic               s2_valid;

  logic signed [66:0] s3_n [3];
  logic signed [65:0] s3_p [3];
  logic signed [32:0] s3_e1 [3];
  logic signed [32:0] s3_e2 [3];
  logic signed [32:0] s3_ao [3];
  logic               s3_valid;

  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    always_ff @(posedge clk) begin
      s2_na[i] <= s1_e1[J] * s1_e2[K];
      s2_nb[i] <= s1_e1[K] * s1_e2[J];
      s2_pa[i] <= s1_ao[J] * dir[K];
      s2_pb[i] <= s1_ao[K] * dir[J];
      s2_e1[i] <= s1_e1[i];
      s2_e2[i] <= s1_e2[i];
      s2_ao[i] <= s1_ao[i];

      s3_n[i]  <= 67'(s2_na[i]) - 67'(s2_nb[i]);
      s3_p[i]  <= 66'(s2_pa[i]) - 66'(s2_pb[i]);
      s3_e1[i] <= s2_e1[i];
      s3_e2[i] <= s2_e2[i];
      s3_ao[i] <= s2_ao[i];
    end
  end

  // Stage 4: wide multiplies split into a low unsigned 34-bit half and a signed high half.
  // Stage 5: halves recombined. Stage 6: dot-product sums.
  logic signed [67:0]  s4_lo [4][3];
  logic signed [65:0]  s4_hi [4][3];
  logic                s4_valid;
  logic signed [101:0] s5_term [4][3];
  logic                s5_valid;
  logic signed [101:0] s6_sum [4];
  logic                s6_valid;

  for (genvar i = 0; i < 3; i++) begin : g_dot
    logic signed [34:0] n_lo;
    logic signed [32:0] n_hi;
    logic signed [34:0] p_lo;
    logic signed [31:0] p_hi;
    logic signed [32:0] dir_x;

    assign n_lo  = $signed({1'b0, s3_n[i][33:0]});
    assign n_hi  = $signed(s3_n[i][66:34]);
    assign p_lo  = $signed({1'b0, s3_p[i][33:0]});
    assign p_hi  = $signed(s3_p[i][65:34]);
    assign dir_x = 33'(dir[i]);

    always_ff @(posedge clk) begin
      s4_lo[DOT_DET][i] <= n_lo * dir_x;
      s4_hi[DOT_DET][i] <= n_hi * dir_x;
      s4_lo[DOT_U][i]   <= p_lo * s3_e2[i];
      s4_hi[DOT_U][i]   <= p_hi * s3_e2[i];
      s4_lo[DOT_V][i]   <= p_lo * s3_e1[i];
      s4_hi[DOT_V][i]   <= p_hi * s3_e1[i];
      s4_lo[DOT_T][i]   <= n_lo * s3_ao[i];
      s4_hi[DOT_T][i]   <= n_hi * s3_ao[i];
      for (int d = 0; d < 4; d++) begin
        s5_term[d][i] <= (102'(s4_hi[d][i]) <<< 34) + 102'(s4_lo[d][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < 4; d++) begin
      s6_sum[d] <= s5_term[d][0] + s5_term[d][1] + s5_term[d][2];
    end
  end

  // Stage 7: determinant and v numerator take their sign.
  logic signed [101:0] s7_det;
  logic signed [101:0] s7_num [3];
  logic                s7_valid;

  always_ff @(posedge clk) begin
    s7_det    <= -s6_sum[DOT_DET];
    s7_num[0] <= s6_sum[DOT_T];
    s7_num[1] <= s6_sum[DOT_U];
    s7_num[2] <= -s6_sum[DOT_V];
  end

  // Stage 8: determinant test, hit test on exact numerators, magnitudes.
  logic [62:0]         thr;
  logic signed [102:0] uv_sum;
  logic                h_reject;
  logic                h_miss;
  logic [101:0]        h_mag [3];

  logic [101:0] s8_mag [3];
  logic         s8_neg [3];
  logic [100:0] s8_det;
  logic         s8_reject;
  logic         s8_miss;
  logic         s8_valid;

  always_comb begin
    thr      = {det_min, 32'b0};
    h_reject = s7_det[101] || (s7_det == '0) || (s7_det[100:0] < 101'(thr));
    uv_sum   = 103'(s7_num[1]) + 103'(s7_num[2]);
    h_miss   = s7_num[0][101] || s7_num[1][101] || s7_num[2][101] ||
               (103'(s7_det) < uv_sum);
    for (int l = 0; l < 3; l++) begin
      h_mag[l] = s7_num[l][101] ? $unsigned(-s7_num[l]) : $unsigned(s7_num[l]);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      s8_mag[l] <= h_mag[l];
      s8_neg[l] <= s7_num[l][101];
    end
    s8_det    <= s7_det[100:0];
    s8_reject <= h_reject;
    s8_miss   <= h_miss;
  end

  // Divider: entry 0 holds the overflow check and the initial remainder, then one
  // quotient bit per stage for each of the three lanes (t, u, v).
  logic [100:0] d_rem [QUOT_BITS+1][3];
  logic [31:0]  d_low [QUOT_BITS+1][3];
  logic [31:0]  d_q [QUOT_BITS+1][3];
  logic         d_ovf [QUOT_BITS+1][3];
  logic         d_neg [QUOT_BITS+1][3];
  logic [100:0] d_det [QUOT_BITS+1];
  logic         d_reject [QUOT_BITS+1];
  logic         d_miss [QUOT_BITS+1];
  logic         dv [QUOT_BITS+1];

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      // The quotient needs more than 32 bits when the top of the scaled numerator
      // already reaches the divisor.
      d_ovf[0][l] <= {15'b0, s8_mag[l][101:16]} >= s8_det;
      d_rem[0][l] <= ({15'b0, s8_mag[l][101:16]} >= s8_det) ? '0
                     : {15'b0, s8_mag[l][101:16]};
      d_low[0][l] <= {s8_mag[l][15:0], 16'b0};
      d_q[0][l]   <= '0;
      d_neg[0][l] <= s8_neg[l];
    end
    d_det[0]    <= s8_det;
    d_reject[0] <= s8_reject;
    d_miss[0]   <= s8_miss;
  end

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [101:0] sh;
      logic [101:0] diff;
      logic         ge;

      assign sh   = {d_rem[k][l], d_low[k][l][31]};
      assign ge   = sh >= {1'b0, d_det[k]};
      assign diff = sh - {1'b0, d_det[k]};

      always_ff @(posedge clk) begin
        d_rem[k+1][l] <= ge ? diff[100:0] : sh[100:0];
        d_low[k+1][l] <= {d_low[k][l][30:0], 1'b0};
        d_q[k+1][l]   <= {d_q[k][l][30:0], ge};
        d_ovf[k+1][l] <= d_ovf[k][l];
        d_neg[k+1][l] <= d_neg[k][l];
      end
    end

    always_ff @(posedge clk) begin
      d_det[k+1]    <= d_det[k];
      d_reject[k+1] <= d_reject[k];
      d_miss[k+1]   <= d_miss[k];
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
      dv       <= '{default: 1'b0};
      done     <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
      s8_valid <= s7_valid;
      dv[0]    <= s8_valid;
      for (int k = 0; k < QUOT_BITS; k++) begin
        dv[k+1] <= dv[k];
      end
      done <= dv[QUOT_BITS];
    end
  end

  // Saturation and result select.
  logic [31:0] f_val [3];
  logic [1:0]  f_outcome;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (d_ovf[QUOT_BITS][l]) begin
        f_val[l] = d_neg[QUOT_BITS][l] ? Q_MIN : Q_MAX;
      end else if (!d_neg[QUOT_BITS][l]) begin
        f_val[l] = d_q[QUOT_BITS][l][31] ? Q_MAX : d_q[QUOT_BITS][l];
      end else begin
        f_val[l] = (d_q[QUOT_BITS][l] > Q_MIN) ? Q_MIN : -d_q[QUOT_BITS][l];
      end
      if (d_reject[QUOT_BITS]) begin
        f_val[l] = '0;
      end
    end
    if (d_reject[QUOT_BITS]) begin
      f_outcome = OUTCOME_REJECT;
    end else if (d_miss[QUOT_BITS]) begin
      f_outcome = OUTCOME_MISS;
    end else begin
      f_outcome = OUTCOME_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (dv[QUOT_BITS]) begin
      outcome      <= f_outcome;
      hit_distance <= f_val[0];
      bary_u       <= f_val[1];
      bary_v       <= f_val[2];
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted item did not produce a result after the pipeline latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(dv[QUOT_BITS]))
    else $error("result strobe without an item in the last divider stage");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    done && outcome == OUTCOME_REJECT |-> hit_distance == '0 && bary_u == '0 && bary_v == '0)
    else $error("rejected triangle with nonzero t, u or v");

  a_hit_nonneg: assert property (@(posedge clk) disable iff (rst)
    done && outcome == OUTCOME_HIT |-> !hit_distance[31] && !bary_u[31] && !bary_v[31])
    else $error("hit reported with a negative t, u or v");

endmodule
